[design/lj_pkg.sv]
// shared widths, limits and register map for the lennard-jones pair kernel
`default_nettype none

package lj_pkg;

    localparam int XW     = 64;  // ratio sigma/d, UQ32.32
    localparam int DW     = 33;  // positive shifted distance
    localparam int RW     = 48;  // result width
    localparam int ADDR_W = 5;   // byte address of the register file

    localparam logic [RW-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [RW-1:0] NEG_MAG = 48'h8000_0000_0000;

    localparam logic [31:0] RST_WELL_DEPTH      = 32'd16777216;
    localparam logic [31:0] RST_ZERO_DISTANCE   = 32'd16777216;
    localparam logic [31:0] RST_ORIGIN_OFFSET   = 32'd0;
    localparam logic [31:0] RST_GUARD_OFFSET    = 32'd1;
    localparam logic [31:0] RST_CUTOFF_DISTANCE = 32'd41943040;

    typedef enum logic [2:0] {
        REG_WELL_DEPTH      = 3'd0,
        REG_ZERO_DISTANCE   = 3'd1,
        REG_ORIGIN_OFFSET   = 3'd2,
        REG_GUARD_OFFSET    = 3'd3,
        REG_CUTOFF_DISTANCE = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

[design/lj_div.sv]
// pipelined restoring divider, SPS quotient bits per stage, with side payload
`default_nettype none

module lj_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int PW    = 8,
    parameter int SPS   = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DEN_W-1:0] i_rem,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [PW-1:0]    i_pay,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_quo,
    output logic [PW-1:0]         o_pay
);
    localparam int NST = NUM_W / SPS;

    logic             r_v   [NST];
    logic [DEN_W-1:0] r_rem [NST];
    logic [DEN_W-1:0] r_den [NST];
    logic [NUM_W-1:0] r_num [NST];
    logic [NUM_W-1:0] r_quo [NST];
    logic [PW-1:0]    r_pay [NST];

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic             s_v;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [NUM_W-1:0] s_num;
        logic [NUM_W-1:0] s_quo;
        logic [PW-1:0]    s_pay;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_num;
        logic [NUM_W-1:0] n_quo;

        if (k == 0) begin : g_in
            assign s_v   = i_valid;
            assign s_rem = i_rem;
            assign s_den = i_den;
            assign s_num = i_num;
            assign s_quo = '0;
            assign s_pay = i_pay;
        end else begin : g_chain
            assign s_v   = r_v[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_num = r_num[k-1];
            assign s_quo = r_quo[k-1];
            assign s_pay = r_pay[k-1];
        end

        always_comb begin
            logic [DEN_W:0] t;
            n_rem = s_rem;
            n_num = s_num;
            n_quo = s_quo;
            for (int s = 0; s < SPS; s++) begin
                t     = {n_rem, n_num[NUM_W-1]};
                n_num = {n_num[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, s_den}) begin
                    t     = t - {1'b0, s_den};
                    n_quo = {n_quo[NUM_W-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[NUM_W-2:0], 1'b0};
                end
                n_rem = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= s_den;
                r_num[k] <= n_num;
                r_quo[k] <= n_quo;
                r_pay[k] <= s_pay;
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_pay   = r_pay[NST-1];

endmodule

`default_nettype wire

[design/lj_fxmul.sv]
// three-stage UQ32.32 multiplier, round half up, sticky overflow
`default_nettype none

module lj_fxmul #(
    parameter int PW = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [lj_pkg::XW-1:0] i_a,
    input  wire logic [lj_pkg::XW-1:0] i_b,
    input  wire logic                 i_ovf,
    input  wire logic [PW-1:0]        i_pay,
    output logic                      o_valid,
    output logic [lj_pkg::XW-1:0]     o_p,
    output logic                      o_ovf,
    output logic [PW-1:0]             o_pay
);
    import lj_pkg::*;

    localparam logic [64:0] HALF = 65'd1 << 31;

    logic          r1_v, r2_v, r3_v;
    logic          r1_ovf, r2_ovf, r3_ovf;
    logic [PW-1:0] r1_pay, r2_pay, r3_pay;
    logic [63:0]   r1_ll, r1_lh, r1_hl, r1_hh, r2_hh;
    logic [64:0]   r2_mid, r2_low;
    logic [XW-1:0] r3_p;
    logic [127:0]  w_full;
    logic          w_of;

    // partial sums combined at the product's 2^32 scale
    assign w_full = {r2_hh, 64'b0} + {31'b0, r2_mid, 32'b0} + {63'b0, r2_low};
    assign w_of   = |w_full[127:96];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ll  <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
            r1_lh  <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
            r1_hl  <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
            r1_hh  <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
            r1_ovf <= i_ovf;
            r1_pay <= i_pay;
            r2_mid <= 65'(r1_lh) + 65'(r1_hl);
            r2_low <= 65'(r1_ll) + HALF;
            r2_hh  <= r1_hh;
            r2_ovf <= r1_ovf;
            r2_pay <= r1_pay;
            r3_p   <= w_of ? '1 : w_full[95:32];
            r3_ovf <= r2_ovf | w_of;
            r3_pay <= r2_pay;
        end
    end

    assign o_valid = r3_v;
    assign o_p     = r3_p;
    assign o_ovf   = r3_ovf;
    assign o_pay   = r3_pay;

endmodule

`default_nettype wire

[design/lennard_jones_pair_kernel_unit.sv]
// lennard-jones 12-6 pair kernel: energy and derivative per pair distance
// results are registered in the output register before they leave
// throughput: one item per cycle unless a held result is stalled; the 64-step
// ratio divider and the 48-step derivative divider retire four quotient bits
// per stage, four multipliers of three stages each form the powers of the ratio
// any stall freezes the pipeline; reset clears valid bits, sets config defaults
`default_nettype none

module lennard_jones_pair_kernel_unit #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [lj_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [31:0]               i_pair_distance,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [lj_pkg::RW-1:0]   o_energy,
    output logic signed [lj_pkg::RW-1:0]   o_derivative,
    output logic                           o_saturated
);
    import lj_pkg::*;

    localparam int WW = 102 + FRAC_BITS;  // scaled derivative numerator
    localparam int NW = WW - 32;          // after dropping the low word
    localparam int HW = NW - RW;          // part above the 48 quotient bits

    typedef struct packed {
        logic          cut;
        logic          bad;
        logic [DW-1:0] d;
    } t_base;

    typedef struct packed {
        t_base         b;
        logic [XW-1:0] x;
    } t_basex;

    typedef struct packed {
        logic          cut;
        logic          bad;
        logic          ovf;
        logic          gneg;
        logic          govf;
        logic          ef;
        logic [RW-1:0] e;
    } t_gpay;

    // configuration registers
    logic [31:0] r_well_depth, r_zero_distance, r_origin_offset;
    logic [31:0] r_guard_offset, r_cutoff_distance;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_well_depth      <= RST_WELL_DEPTH;
            r_zero_distance   <= RST_ZERO_DISTANCE;
            r_origin_offset   <= RST_ORIGIN_OFFSET;
            r_guard_offset    <= RST_GUARD_OFFSET;
            r_cutoff_distance <= RST_CUTOFF_DISTANCE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WELL_DEPTH:      r_well_depth      <= pwdata;
                REG_ZERO_DISTANCE:   r_zero_distance   <= pwdata;
                REG_ORIGIN_OFFSET:   r_origin_offset   <= pwdata;
                REG_GUARD_OFFSET:    r_guard_offset    <= pwdata;
                REG_CUTOFF_DISTANCE: r_cutoff_distance <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WELL_DEPTH:      prdata = r_well_depth;
            REG_ZERO_DISTANCE:   prdata = r_zero_distance;
            REG_ORIGIN_OFFSET:   prdata = r_origin_offset;
            REG_GUARD_OFFSET:    prdata = r_guard_offset;
            REG_CUTOFF_DISTANCE: prdata = r_cutoff_distance;
            default:             prdata = '0;
        endcase
    end

    // pipeline advance
    logic r_out_v;
    logic w_adv;

    assign w_adv   = !r_out_v || !i_stall;
    assign o_stall = !w_adv;

    // stage 1: shifted distance and cutoff
    logic signed [34:0] w_ds;
    t_base              n_s1, r_s1;
    logic               r_s1_v;

    assign w_ds = $signed({3'b0, i_pair_distance}) - $signed({3'b0, r_origin_offset})
                + $signed({3'b0, r_guard_offset});

    always_comb begin
        n_s1.cut = i_pair_distance > r_cutoff_distance;
        n_s1.bad = w_ds[34] || (w_ds == '0);
        // keep the divisor nonzero on the flagged path
        n_s1.d   = n_s1.bad ? DW'(1) : w_ds[DW-1:0];
    end

    // ratio x = sigma * 2^32 / d
    logic          w_x_v;
    logic [XW-1:0] w_x_q;
    t_base         w_x_pay;

    lj_div #(.NUM_W(XW), .DEN_W(DW), .PW($bits(t_base)), .SPS(4)) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s1_v),
        .i_rem   ('0),
        .i_num   ({r_zero_distance, 32'b0}),
        .i_den   (r_s1.d),
        .i_pay   (r_s1),
        .o_valid (w_x_v),
        .o_quo   (w_x_q),
        .o_pay   (w_x_pay)
    );

    // powers x^2, x^3, x^6, x^12
    logic          w_f1_v, w_f2_v, w_f3_v, w_f4_v;
    logic [XW-1:0] w_f1_p, w_f2_p, w_f3_p, w_f4_p;
    logic          w_f1_o, w_f2_o, w_f3_o, w_f4_o;
    t_basex        w_f1_pay, w_f4_pay;
    t_base         w_f2_pay, w_f3_pay;

    lj_fxmul #(.PW($bits(t_basex))) u_fx2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_valid (w_x_v), .i_a (w_x_q), .i_b (w_x_q), .i_ovf (1'b0),
        .i_pay ({w_x_pay, w_x_q}),
        .o_valid (w_f1_v), .o_p (w_f1_p), .o_ovf (w_f1_o), .o_pay (w_f1_pay)
    );

    lj_fxmul #(.PW($bits(t_base))) u_fx3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_valid (w_f1_v), .i_a (w_f1_p), .i_b (w_f1_pay.x), .i_ovf (w_f1_o),
        .i_pay (w_f1_pay.b),
        .o_valid (w_f2_v), .o_p (w_f2_p), .o_ovf (w_f2_o), .o_pay (w_f2_pay)
    );

    lj_fxmul #(.PW($bits(t_base))) u_fx6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_valid (w_f2_v), .i_a (w_f2_p), .i_b (w_f2_p), .i_ovf (w_f2_o),
        .i_pay (w_f2_pay),
        .o_valid (w_f3_v), .o_p (w_f3_p), .o_ovf (w_f3_o), .o_pay (w_f3_pay)
    );

    lj_fxmul #(.PW($bits(t_basex))) u_fx12 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_adv),
        .i_valid (w_f3_v), .i_a (w_f3_p), .i_b (w_f3_p), .i_ovf (w_f3_o),
        .i_pay ({w_f3_pay, w_f3_p}),
        .o_valid (w_f4_v), .o_p (w_f4_p), .o_ovf (w_f4_o), .o_pay (w_f4_pay)
    );

    // stage m: signed differences x^12 - x^6 and x^6 - 2x^12
    logic          r_m_v, r_m_ovf, r_m_eneg, r_m_gneg;
    t_base         r_m_b;
    logic [XW-1:0] r_m_emag;
    logic [XW:0]   r_m_gmag;
    logic          w_eneg, w_gneg;
    logic [XW:0]   w_t2;

    assign w_eneg = w_f4_p < w_f4_pay.x;
    assign w_t2   = {w_f4_p, 1'b0};
    assign w_gneg = w_t2 > {1'b0, w_f4_pay.x};

    // stage p: partial products with epsilon
    logic        r_p_v, r_p_ovf, r_p_eneg, r_p_gneg;
    t_base       r_p_b;
    logic [63:0] r_p_elo, r_p_ehi, r_p_glo;
    logic [64:0] r_p_ghi;

    // stage q: energy rounded, derivative product summed
    logic        r_q_v, r_q_ovf, r_q_eneg, r_q_gneg;
    t_base       r_q_b;
    logic [65:0] r_q_eq;
    logic [96:0] r_q_g;
    logic [97:0] w_e;

    assign w_e = {r_p_ehi, 34'b0} + {32'b0, r_p_elo, 2'b0} + (98'd1 << 31);

    // stage r: times 24, energy clamp
    logic          r_r_v, r_r_ovf, r_r_gneg, r_r_ef;
    t_base         r_r_b;
    logic [101:0]  r_r_t;
    logic [RW-1:0] r_r_e;
    logic          w_ef;
    logic [RW-1:0] w_ev;

    always_comb begin
        if (!r_q_eneg) begin
            w_ef = r_q_eq > 66'(POS_MAX);
            w_ev = w_ef ? POS_MAX : r_q_eq[RW-1:0];
        end else begin
            w_ef = r_q_eq > 66'(NEG_MAG);
            w_ev = w_ef ? NEG_MAG : RW'(0 - r_q_eq[RW-1:0]);
        end
    end

    // stage s: fraction scaling plus half divisor for rounding
    logic          r_s_v, r_s_ovf, r_s_gneg, r_s_ef;
    t_base         r_s_b;
    logic [RW-1:0] r_s_e;
    logic [NW-1:0] r_s_num;
    logic [WW-1:0] w_wide;

    assign w_wide = {r_r_t, {FRAC_BITS{1'b0}}} + WW'({r_r_b.d, 31'b0});

    // stage u: quotient overflow test and divider seed
    logic          r_u_v;
    t_gpay         r_u_pay;
    logic [DW-1:0] r_u_rem, r_u_d;
    logic [RW-1:0] r_u_low;
    logic          w_govf;

    assign w_govf = r_s_num[NW-1:RW] >= HW'(r_s_b.d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_m_v  <= 1'b0;
            r_p_v  <= 1'b0;
            r_q_v  <= 1'b0;
            r_r_v  <= 1'b0;
            r_s_v  <= 1'b0;
            r_u_v  <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= i_valid;
            r_m_v  <= w_f4_v;
            r_p_v  <= r_m_v;
            r_q_v  <= r_p_v;
            r_r_v  <= r_q_v;
            r_s_v  <= r_r_v;
            r_u_v  <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1     <= n_s1;

            r_m_b    <= w_f4_pay.b;
            r_m_ovf  <= w_f4_o;
            r_m_eneg <= w_eneg;
            r_m_emag <= w_eneg ? w_f4_pay.x - w_f4_p : w_f4_p - w_f4_pay.x;
            r_m_gneg <= w_gneg;
            r_m_gmag <= w_gneg ? w_t2 - {1'b0, w_f4_pay.x} : {1'b0, w_f4_pay.x} - w_t2;

            r_p_b    <= r_m_b;
            r_p_ovf  <= r_m_ovf;
            r_p_eneg <= r_m_eneg;
            r_p_gneg <= r_m_gneg;
            r_p_elo  <= 64'(r_m_emag[31:0]) * 64'(r_well_depth);
            r_p_ehi  <= 64'(r_m_emag[63:32]) * 64'(r_well_depth);
            r_p_glo  <= 64'(r_m_gmag[31:0]) * 64'(r_well_depth);
            r_p_ghi  <= 65'(r_m_gmag[64:32]) * 65'(r_well_depth);

            r_q_b    <= r_p_b;
            r_q_ovf  <= r_p_ovf;
            r_q_eneg <= r_p_eneg;
            r_q_gneg <= r_p_gneg;
            r_q_eq   <= w_e[97:32];
            r_q_g    <= {r_p_ghi, 32'b0} + {33'b0, r_p_glo};

            r_r_b    <= r_q_b;
            r_r_ovf  <= r_q_ovf;
            r_r_gneg <= r_q_gneg;
            r_r_t    <= {1'b0, r_q_g, 4'b0} + {2'b0, r_q_g, 3'b0};
            r_r_e    <= w_ev;
            r_r_ef   <= w_ef;

            r_s_b    <= r_r_b;
            r_s_ovf  <= r_r_ovf;
            r_s_gneg <= r_r_gneg;
            r_s_e    <= r_r_e;
            r_s_ef   <= r_r_ef;
            r_s_num  <= w_wide[WW-1:32];

            r_u_pay.cut  <= r_s_b.cut;
            r_u_pay.bad  <= r_s_b.bad;
            r_u_pay.ovf  <= r_s_ovf;
            r_u_pay.gneg <= r_s_gneg;
            r_u_pay.govf <= w_govf;
            r_u_pay.ef   <= r_s_ef;
            r_u_pay.e    <= r_s_e;
            r_u_rem      <= w_govf ? '0 : r_s_num[RW +: DW];
            r_u_low      <= r_s_num[RW-1:0];
            r_u_d        <= r_s_b.d;
        end
    end

    // derivative magnitude divided by d
    logic          w_g_v;
    logic [RW-1:0] w_g_q;
    t_gpay         w_g_pay;

    lj_div #(.NUM_W(RW), .DEN_W(DW), .PW($bits(t_gpay)), .SPS(4)) u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_u_v),
        .i_rem   (r_u_rem),
        .i_num   (r_u_low),
        .i_den   (r_u_d),
        .i_pay   (r_u_pay),
        .o_valid (w_g_v),
        .o_quo   (w_g_q),
        .o_pay   (w_g_pay)
    );

    // final selection into the output register
    logic          w_gf;
    logic [RW-1:0] w_gv;
    logic [RW-1:0] n_out_e, n_out_g;
    logic          n_out_sat;
    logic [RW-1:0] r_out_e, r_out_g;
    logic          r_out_sat;

    always_comb begin
        if (!w_g_pay.gneg) begin
            w_gf = w_g_pay.govf || (w_g_q > POS_MAX);
            w_gv = w_gf ? POS_MAX : w_g_q;
        end else begin
            w_gf = w_g_pay.govf || (w_g_q > NEG_MAG);
            w_gv = w_gf ? NEG_MAG : RW'(0 - w_g_q);
        end
        priority if (w_g_pay.cut) begin
            n_out_e   = '0;
            n_out_g   = '0;
            n_out_sat = 1'b0;
        end else if (w_g_pay.bad || w_g_pay.ovf) begin
            n_out_e   = POS_MAX;
            n_out_g   = NEG_MAG;
            n_out_sat = 1'b1;
        end else begin
            n_out_e   = w_g_pay.e;
            n_out_g   = w_gv;
            n_out_sat = w_g_pay.ef || w_gf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_e   <= n_out_e;
            r_out_g   <= n_out_g;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid      = r_out_v;
    assign o_energy     = $signed(r_out_e);
    assign o_derivative = $signed(r_out_g);
    assign o_saturated  = r_out_sat;

endmodule

`default_nettype wire

[design/lj_chk.sv]
// port-level checks for the lennard-jones pair kernel, bound to the top level
`default_nettype none

module lj_chk (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic                    o_stall,
    input wire logic [lj_pkg::RW-1:0]   o_energy,
    input wire logic [lj_pkg::RW-1:0]   o_derivative,
    input wire logic                    o_saturated,
    input wire logic                    pready
);
    import lj_pkg::*;

    // input side backs up only when a held result is stalled
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_energy) && $stable(o_derivative)
            && $stable(o_saturated))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind lennard_jones_pair_kernel_unit lj_chk u_lj_chk (.*);

`default_nettype wire

[tb/sv/lennard_jones_pair_kernel_unit_tb.sv]
// testbench for the lennard-jones pair kernel: random and directed distances, scoreboard check
`default_nettype none

class lj_scoreboard;
    typedef struct {
        logic signed [47:0] energy;
        logic signed [47:0] derivative;
        logic               saturated;
    } t_pair_result;

    logic [31:0]  reg_val [5];
    t_pair_result expected_q [$];
    int           mismatches;
    int           checked;
    int           saturations;

    function new();
        reg_val[lj_pkg::REG_WELL_DEPTH]      = lj_pkg::RST_WELL_DEPTH;
        reg_val[lj_pkg::REG_ZERO_DISTANCE]   = lj_pkg::RST_ZERO_DISTANCE;
        reg_val[lj_pkg::REG_ORIGIN_OFFSET]   = lj_pkg::RST_ORIGIN_OFFSET;
        reg_val[lj_pkg::REG_GUARD_OFFSET]    = lj_pkg::RST_GUARD_OFFSET;
        reg_val[lj_pkg::REG_CUTOFF_DISTANCE] = lj_pkg::RST_CUTOFF_DISTANCE;
        mismatches = 0;
        checked = 0;
        saturations = 0;
    endfunction

    // ratio product in UQ32.32, rounded half up; flags a carry out of 64 bits
    function logic [63:0] ratio_mul(input logic [63:0] a, input logic [63:0] b,
                                    inout logic ovf);
        logic [128:0] p;
        p = {65'd0, a} * {65'd0, b} + 129'h8000_0000;
        if (p[128:96] != 0) begin
            ovf = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    // round(mag * eps * k * 2^shift / (2^32 * div)), signed and clamped to 48 bits
    function logic [47:0] scaled_result(input logic [65:0] mag, input int k, input int shift,
                                        input logic [63:0] div, input logic neg,
                                        inout logic flag);
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] q;
        num = ({126'd0, mag} * {160'd0, reg_val[lj_pkg::REG_WELL_DEPTH]}
               * {160'd0, k[31:0]}) << shift;
        den = {128'd0, div} << 32;
        q = (num + ({128'd0, div} << 31)) / den;
        if (!neg) begin
            if (q > lj_pkg::POS_MAX) begin
                flag = 1'b1;
                return lj_pkg::POS_MAX;
            end
            return q[47:0];
        end
        if (q > lj_pkg::NEG_MAG) begin
            flag = 1'b1;
            return lj_pkg::NEG_MAG;
        end
        return 48'd0 - q[47:0];
    endfunction

    function t_pair_result pair_energy(input logic [31:0] r);
        t_pair_result res;
        logic signed [35:0] ds;
        logic [63:0] d, x, x2, x3, x6, x12;
        logic [95:0] num;
        logic [95:0] quo;
        logic [65:0] twice, mag;
        logic ovf, flag, neg;
        ovf = 1'b0;
        flag = 1'b0;
        res.energy = '0;
        res.derivative = '0;
        res.saturated = 1'b0;
        if (r > reg_val[lj_pkg::REG_CUTOFF_DISTANCE]) return res;
        ds = $signed({4'd0, r}) - $signed({4'd0, reg_val[lj_pkg::REG_ORIGIN_OFFSET]})
             + $signed({4'd0, reg_val[lj_pkg::REG_GUARD_OFFSET]});
        res.energy = lj_pkg::POS_MAX;
        res.derivative = lj_pkg::NEG_MAG;
        res.saturated = 1'b1;
        if (ds <= 36'sd0) return res;
        d = {28'd0, ds};
        num = {32'd0, reg_val[lj_pkg::REG_ZERO_DISTANCE], 32'd0};
        quo = num / {32'd0, d};
        x = quo[63:0];
        x2 = ratio_mul(x, x, ovf);
        x3 = ratio_mul(x2, x, ovf);
        x6 = ratio_mul(x3, x3, ovf);
        x12 = ratio_mul(x6, x6, ovf);
        if (ovf) return res;
        if (x12 >= x6)
            res.energy = scaled_result({2'd0, x12 - x6}, 4, 0, 64'd1, 1'b0, flag);
        else
            res.energy = scaled_result({2'd0, x6 - x12}, 4, 0, 64'd1, 1'b1, flag);
        twice = {2'd0, x12} << 1;
        neg = twice > {2'd0, x6};
        mag = neg ? twice - {2'd0, x6} : {2'd0, x6} - twice;
        res.derivative = scaled_result(mag, 24, 24, d, neg, flag);
        res.saturated = flag;
        return res;
    endfunction

    function void note_distance(input logic [31:0] r);
        expected_q.push_back(pair_energy(r));
    endfunction

    function void check_result(input logic signed [47:0] energy,
                               input logic signed [47:0] derivative, input logic saturated);
        t_pair_result exp_res;
        checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result transfer with nothing expected");
            return;
        end
        exp_res = expected_q.pop_front();
        if (saturated) saturations++;
        if (energy !== exp_res.energy || derivative !== exp_res.derivative
                || saturated !== exp_res.saturated) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp e=%h d=%h s=%b got e=%h d=%h s=%b",
                         checked, exp_res.energy, exp_res.derivative, exp_res.saturated,
                         energy, derivative, saturated);
        end
    endfunction
endclass

module lennard_jones_pair_kernel_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 60;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [lj_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [31:0] i_pair_distance;
    logic        o_valid, i_stall;
    logic signed [lj_pkg::RW-1:0] o_energy, o_derivative;
    logic        o_saturated;

    lj_scoreboard sb;
    int  idle_cycles;
    int  sent;
    logic hold_req;

    lennard_jones_pair_kernel_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_pair_distance(i_pair_distance),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_energy(o_energy), .o_derivative(o_derivative), .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor both channels and the idle watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_distance(i_pair_distance);
            if (o_valid && !i_stall) sb.check_result(o_energy, o_derivative, o_saturated);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode, n;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 40);
            repeat (n) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(input lj_pkg::t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lj_pkg::ADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.reg_val[idx] = value;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] eps, input logic [31:0] sigma,
                               input logic [31:0] center, input logic [31:0] delta,
                               input logic [31:0] cutoff);
        wait_drained();
        reg_write(lj_pkg::REG_WELL_DEPTH, eps);
        reg_write(lj_pkg::REG_ZERO_DISTANCE, sigma);
        reg_write(lj_pkg::REG_ORIGIN_OFFSET, center);
        reg_write(lj_pkg::REG_GUARD_OFFSET, delta);
        reg_write(lj_pkg::REG_CUTOFF_DISTANCE, cutoff);
    endtask

    // hold valid with a stable payload until the transfer happens
    task automatic send_distance(input logic [31:0] r);
        i_valid <= 1'b1;
        i_pair_distance <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [31:0] pick_distance();
        logic [63:0] t;
        logic [31:0] sigma, center, cutoff;
        sigma = sb.reg_val[lj_pkg::REG_ZERO_DISTANCE];
        center = sb.reg_val[lj_pkg::REG_ORIGIN_OFFSET];
        cutoff = sb.reg_val[lj_pkg::REG_CUTOFF_DISTANCE];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // around the well, where the powers stay in range
                t = {32'd0, center}
                    + ({32'd0, sigma} * {32'd0, $urandom_range(60, 400)}) / 64'd100
                    + {32'd0, $urandom_range(0, 255)};
                return t[31:0];
            end
            5, 6: return $urandom;
            7: return cutoff + $urandom_range(0, 4) - 32'd2;
            8: return $urandom_range(0, 255);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_items(input int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && count > 0) begin
                send_distance(pick_distance());
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        sent = 0;
        hold_req = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_pair_distance = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero distance overflow, past cutoff, cutoff edge, zero crossing
        send_distance(32'd0);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'd41943040);
        send_distance(32'd41943041);
        send_distance(32'd16777215);
        send_distance(32'd18831669);
        send_distance(32'd33554432);
        send_distance(32'd12000000);
        i_valid <= 1'b0;

        load_config(32'h0100_0000, 32'h0100_0000, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h8000_0000);
        send_distance(32'h0000_0001);
        send_distance(32'h1000_0000);
        i_valid <= 1'b0;
        random_items(140);

        // guard zero: distance equal to center gives a non-positive shifted distance
        load_config(32'hFFFF_FFFF, 32'h0100_0000, 32'h0080_0000, 32'd0, 32'h0300_0000);
        send_distance(32'h0080_0000);
        send_distance(32'h0000_0000);
        send_distance(32'h0180_0000);
        i_valid <= 1'b0;
        random_items(140);

        // zero well depth with huge sigma; maximum guard
        load_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(140);

        // long hold-off on the result side so the pipeline backs up
        load_config(32'h0040_0000, 32'h0180_0000, 32'h0200_0000, 32'h100, 32'h0800_0000);
        hold_req = 1'b1;
        random_items(160);

        // smallest sigma, largest center
        load_config(32'h1000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        random_items(120);

        // zero cutoff: only a zero distance reaches the kernel
        load_config(32'h0100_0000, 32'h00C0_0000, 32'd0, 32'd1, 32'd0);
        send_distance(32'd0);
        i_valid <= 1'b0;
        random_items(80);

        wait_drained();
        $display("sent %0d distances over seven register settings", sent);
        $display("checked %0d results, %0d of them saturated", sb.checked, sb.saturations);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
design/lj_pkg.sv
design/lj_div.sv
design/lj_fxmul.sv
design/lennard_jones_pair_kernel_unit.sv
design/lj_chk.sv
tb/sv/lennard_jones_pair_kernel_unit_tb.sv
